>>> design/chm_pkg.sv
package chm_pkg;

   // bucket count is a power of two, so the hash is the low key bits
   localparam int BucketBits  = 4;
   localparam int NumBuckets  = 1 << BucketBits;
   localparam int BucketSlots = 4;
   localparam int SlotBits    = (BucketSlots > 1) ? $clog2(BucketSlots) : 1;
   localparam int TotalSlots  = NumBuckets * BucketSlots;
   localparam int CountBits   = 7;

   // operation codes
   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpLookup = 2'd1;
   localparam logic [1:0] OpRemove = 2'd2;

   typedef logic [30:0]          key_type;
   typedef logic signed [31:0]   value_type;
   typedef logic [BucketBits-1:0] bucket_type;
   typedef logic [SlotBits-1:0]  slot_idx_type;
   typedef logic [BucketSlots-1:0] slot_vec_type;
   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      key_type   key;
      value_type value;
   } slot_type;

   typedef slot_type [BucketSlots-1:0] row_type;

   // outcome of comparing one bucket against a key
   typedef struct packed {
      logic         hit;
      slot_idx_type hit_slot;
      logic         free;
      slot_idx_type free_slot;
   } match_type;

endpackage

>>> design/chm_bucket_ram.sv
module chm_bucket_ram (
   input  logic                clock,
   input  logic                rd_en,
   input  chm_pkg::bucket_type rd_addr,
   output chm_pkg::row_type    rd_data,
   input  logic                wr_en,
   input  chm_pkg::bucket_type wr_addr,
   input  chm_pkg::row_type    wr_data
);
   import chm_pkg::*;

   row_type mem [NumBuckets];
   row_type rd_data_ff;

   // one bucket row per address, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/chm_match.sv
module chm_match (
   input  chm_pkg::key_type      key,
   input  chm_pkg::row_type      row,
   input  chm_pkg::slot_vec_type valid,
   output chm_pkg::match_type    result
);
   import chm_pkg::*;

   // all slots compared side by side, lowest matching and lowest free slot win
   always_comb begin
      result = '0;
      for (int s = BucketSlots - 1; s >= 0; s--) begin
         if (valid[s]) begin
            if (row[s].key == key) begin
               result.hit      = 1'b1;
               result.hit_slot = SlotBits'(s);
            end
         end else begin
            result.free      = 1'b1;
            result.free_slot = SlotBits'(s);
         end
      end
   end

endmodule

>>> design/chained_hash_map.sv
// Key-value map of NumBuckets buckets with BucketSlots slots each.
// Request channel: req_op, req_key, req_value are taken at a rising edge
// where start is high and busy is low. Op insert stores or updates a pair,
// lookup returns the stored value, remove clears the pair.
// Response channel: rsp_valid is high for exactly one cycle with rsp_found,
// rsp_value_out, rsp_status (bucket full on insert) and rsp_entry_count.
// The receiver cannot stall; every response is taken in its strobe cycle.
// Timing: the bucket row is read from a synchronous memory at the accept
// edge, then compared in UPDATE and written back in the cycle after; the
// response is registered at the write-back edge. busy is high for one cycle
// after each accept, so a new request is not taken until the bucket memory
// has been read and written back for the previous one.
// Reset clears all slot valid bits and the pair count at once; the key and
// value memory is not cleared, so a request may follow reset directly.
module chained_hash_map (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  chm_pkg::key_type    req_key,
   input  chm_pkg::value_type  req_value,
   output logic                rsp_valid,
   output logic                rsp_found,
   output chm_pkg::value_type  rsp_value_out,
   output logic                rsp_status,
   output chm_pkg::count_type  rsp_entry_count
);
   import chm_pkg::*;

   typedef enum logic {
      IDLE,
      UPDATE
   } state_type;

   state_type  state_ff;
   logic [1:0] op_ff;
   key_type    key_ff;
   value_type  value_ff;
   bucket_type bucket_ff;
   logic [TotalSlots-1:0] valid_ff, valid_in;
   count_type  count_ff, count_in;
   logic       rsp_valid_ff, rsp_found_ff, rsp_status_ff;
   value_type  rsp_value_ff;

   logic       accept;
   row_type    rd_row, wr_row;
   logic       wr_en;
   slot_vec_type bucket_valid, bucket_valid_in;
   match_type  match;
   logic       found_in, status_in;
   value_type  value_out_in;

   assign accept = start && (state_ff == IDLE);
   assign busy   = (state_ff != IDLE);

   chm_bucket_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_key[BucketBits-1:0]),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data (wr_row)
   );

   assign bucket_valid = valid_ff[bucket_ff * BucketSlots +: BucketSlots];

   chm_match u_match (
      .key    (key_ff),
      .row    (rd_row),
      .valid  (bucket_valid),
      .result (match)
   );

   // apply the operation to the bucket just read
   always_comb begin
      wr_row          = rd_row;
      wr_en           = 1'b0;
      bucket_valid_in = bucket_valid;
      count_in        = count_ff;
      found_in        = match.hit;
      status_in       = 1'b0;
      value_out_in    = '0;
      unique case (op_ff)
         OpInsert: begin
            if (match.hit) begin
               wr_row[match.hit_slot].value = value_ff;
               wr_en = 1'b1;
            end else if (match.free) begin
               wr_row[match.free_slot].key   = key_ff;
               wr_row[match.free_slot].value = value_ff;
               bucket_valid_in[match.free_slot] = 1'b1;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               status_in = 1'b1;
            end
         end
         OpLookup: begin
            if (match.hit) begin
               value_out_in = rd_row[match.hit_slot].value;
            end
         end
         OpRemove: begin
            if (match.hit) begin
               bucket_valid_in[match.hit_slot] = 1'b0;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (state_ff != UPDATE) begin
         wr_en = 1'b0;
      end
   end

   // updated valid vector for the whole store
   always_comb begin
      valid_in = valid_ff;
      valid_in[bucket_ff * BucketSlots +: BucketSlots] = bucket_valid_in;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         key_ff    <= req_key;
         value_ff  <= req_value;
         bucket_ff <= req_key[BucketBits-1:0];
      end
   end

   // sequencer, valid bits, count and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= UPDATE;
               end
            end
            UPDATE: begin
               valid_ff     <= valid_in;
               count_ff     <= count_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (state_ff == UPDATE) begin
         rsp_found_ff  <= found_in;
         rsp_status_ff <= status_in;
         rsp_value_ff  <= value_out_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_entry_count = count_ff;

endmodule

>>> bench/tb_chained_hash_map.sv
module tb_chained_hash_map;

   import chm_pkg::*;

   localparam logic [1:0] OpUnused = 2'd3;
   localparam int IdleLimit = 2000;

   typedef struct {
      logic [1:0] op;
      key_type    key;
      value_type  value;
      int         gap;
      bit         hold;
   } map_request;

   typedef struct {
      logic      found;
      value_type value_out;
      logic      status;
      count_type entry_count;
   } map_response;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = OpInsert;
   key_type            req_key = '0;
   value_type          req_value = '0;
   logic               rsp_valid;
   logic               rsp_found;
   value_type          rsp_value_out;
   logic               rsp_status;
   count_type          rsp_entry_count;

   // shadow copy of the map contents
   key_type            shadow_keys [TotalSlots];
   value_type          shadow_values [TotalSlots];
   bit                 shadow_used [TotalSlots];
   int                 shadow_pairs;

   map_request         pending_requests [$];
   map_response        expected_responses [$];
   map_request         active_req;
   key_type            hot_keys [48];
   int                 gap_count;
   int                 idle_cycles;
   int                 failures;

   chained_hash_map u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow map and queue the response it causes
   function automatic void apply_to_map(map_request r);
      int          base;
      int          hit;
      int          free_slot;
      map_response resp;
      base = int'(r.key % NumBuckets) * BucketSlots;
      hit = -1;
      free_slot = -1;
      for (int s = 0; s < BucketSlots; s++) begin
         if (shadow_used[base + s]) begin
            if (hit < 0 && shadow_keys[base + s] == r.key) hit = base + s;
         end else if (free_slot < 0) begin
            free_slot = base + s;
         end
      end
      resp.found = (hit >= 0);
      resp.value_out = '0;
      resp.status = 1'b0;
      case (r.op)
         OpInsert: begin
            if (hit >= 0) begin
               shadow_values[hit] = r.value;
            end else if (free_slot >= 0) begin
               shadow_keys[free_slot] = r.key;
               shadow_values[free_slot] = r.value;
               shadow_used[free_slot] = 1'b1;
               shadow_pairs++;
            end else begin
               resp.status = 1'b1;
            end
         end
         OpLookup: begin
            if (hit >= 0) resp.value_out = shadow_values[hit];
         end
         OpRemove: begin
            if (hit >= 0) begin
               shadow_used[hit] = 1'b0;
               if (shadow_pairs > 0) shadow_pairs--;
            end
         end
         default: ;
      endcase
      resp.entry_count = count_type'(shadow_pairs);
      expected_responses = {expected_responses, resp};
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   task automatic add_request(logic [1:0] op, key_type key, value_type value, bit hold);
      map_request r;
      r.op = op;
      r.key = key;
      r.value = value;
      r.gap = pick_gap();
      r.hold = hold;
      pending_requests = {pending_requests, r};
   endtask

   // driver: present queued requests, each after its gap
   always @(posedge clock) begin
      logic go;
      go = start;
      if (reset) begin
         go = 1'b0;
         gap_count = 0;
      end else begin
         if (start && !busy) begin
            apply_to_map(active_req);
            go = 1'b0;
         end
         if (!go && pending_requests.size() > 0) begin
            if (pending_requests[0].hold && expected_responses.size() > 0) begin
               gap_count = 0;
            end else if (gap_count < pending_requests[0].gap) begin
               gap_count++;
            end else begin
               active_req = pending_requests.pop_front();
               gap_count = 0;
               req_op <= active_req.op;
               req_key <= active_req.key;
               req_value <= active_req.value;
               go = 1'b1;
            end
         end
      end
      start <= go;
   end

   // monitor: compare each response with the oldest expectation
   always @(posedge clock) begin
      map_response exp_resp;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response: found %0d value_out %0d entry_count %0d",
                   rsp_found, rsp_value_out, rsp_entry_count);
            failures++;
         end else begin
            exp_resp = expected_responses.pop_front();
            if (rsp_found !== exp_resp.found) begin
               $error("rsp_found: expected %0d, actual %0d", exp_resp.found, rsp_found);
               failures++;
            end
            if (rsp_value_out !== exp_resp.value_out) begin
               $error("rsp_value_out: expected %0d, actual %0d",
                      exp_resp.value_out, rsp_value_out);
               failures++;
            end
            if (rsp_status !== exp_resp.status) begin
               $error("rsp_status: expected %0d, actual %0d", exp_resp.status, rsp_status);
               failures++;
            end
            if (rsp_entry_count !== exp_resp.entry_count) begin
               $error("rsp_entry_count: expected %0d, actual %0d",
                      exp_resp.entry_count, rsp_entry_count);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no request taken and no response
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int        r;
      int        bucket;
      logic [1:0] op;
      key_type   key;
      failures = 0;
      shadow_pairs = 0;
      for (int i = 0; i < TotalSlots; i++) shadow_used[i] = 1'b0;

      // directed: field extremes, every operation, full bucket and slot reuse
      add_request(OpInsert, 31'd0, 32'sh7FFF_FFFF, 1'b0);
      add_request(OpInsert, 31'h7FFF_FFFF, 32'sh8000_0000, 1'b0);
      add_request(OpLookup, 31'd0, 32'sh5555_AAAA, 1'b0);
      add_request(OpLookup, 31'h7FFF_FFFF, 32'sh0, 1'b0);
      add_request(OpLookup, 31'd16, 32'sh0, 1'b0);
      add_request(OpInsert, 31'd3, 32'sd1, 1'b0);
      add_request(OpInsert, 31'd19, 32'sd2, 1'b0);
      add_request(OpInsert, 31'd35, 32'sd3, 1'b0);
      add_request(OpInsert, 31'd51, 32'sd4, 1'b0);
      add_request(OpInsert, 31'd67, 32'sd5, 1'b0);
      add_request(OpInsert, 31'd19, -32'sd20, 1'b0);
      add_request(OpLookup, 31'd19, 32'sh0, 1'b0);
      add_request(OpRemove, 31'd35, 32'sh0, 1'b0);
      add_request(OpInsert, 31'd67, 32'sd6, 1'b0);
      add_request(OpLookup, 31'd67, 32'sh0, 1'b0);
      add_request(OpRemove, 31'd83, 32'sh0, 1'b0);
      add_request(OpUnused, 31'd51, 32'sh1234_5678, 1'b0);
      add_request(OpUnused, 31'd99, 32'sh0, 1'b0);
      add_request(OpRemove, 31'd0, 32'shFFFF_FFFF, 1'b0);
      add_request(OpLookup, 31'd0, 32'sh0, 1'b0);
      add_request(OpRemove, 31'h7FFF_FFFF, 32'sh0, 1'b0);
      add_request(OpInsert, 31'h7FFF_FFFF, 32'sh0, 1'b0);

      // hot keys: six per chosen bucket so buckets fill and overflow
      for (int b = 0; b < 8; b++) begin
         bucket = $urandom_range(0, NumBuckets - 1);
         for (int j = 0; j < 6; j++)
            hot_keys[b * 6 + j] = key_type'(($urandom() << BucketBits) | bucket);
      end

      // random part, with drain pauses and bursts without gaps
      for (int i = 0; i < 800; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op = OpInsert;
         else if (r < 75) op = OpLookup;
         else if (r < 95) op = OpRemove;
         else op = OpUnused;
         if ($urandom_range(0, 99) < 75) key = hot_keys[$urandom_range(0, 47)];
         else key = key_type'($urandom());
         add_request(op, key, value_type'($urandom()), i == 0 || i == 400);
         if (i % 200 < 50) pending_requests[$].gap = 0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || start || expected_responses.size() > 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
